FILE: design/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies

`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic push;
        logic pop;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_push;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/double_ended_queue_top.sv
// top level of the double-ended queue: controller plus datapath
// depends on deq_pkg, deq_ctrl, deq_dp and deq_ram

// Each input item is one command (push front, push back, pop back, pop front) and
// yields exactly one result item with the popped value (zero unless a pop
// succeeded), a status (ok, underflow on an empty pop, overflow on a full push)
// and the entry count after the command, reported in 5 bits. A command is
// accepted, then accesses the single-port entry ram and moves the head pointer
// and count, then loads the output register once that register is free. The next
// command is accepted as soon as the result sits in the output register, even if
// it has not been taken yet. Entries live in a ram of DEPTH words that needs no
// clearing after reset.

`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // value[31:0]
    input  wire logic [1:0]  i_s_axis_tuser,  // cmd[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,  // popped_value[31:0], count[36:32], zero[39:37]
    output logic      [1:0]  o_m_axis_tuser   // status[1:0]
);

    import deq_pkg::*;

    t_dp_cmd            cmd_bus;
    t_dp_stat           stat;
    logic [VALUE_W-1:0] popped_value;
    t_status            status;
    logic [COUNT_W-1:0] count;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .i_stat     (stat),
        .o_cmd_bus  (cmd_bus)
    );

    deq_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_bus     (cmd_bus),
        .o_stat        (stat),
        .i_cmd         (t_cmd'(i_s_axis_tuser)),
        .i_value       (i_s_axis_tdata),
        .o_popped_value(popped_value),
        .o_status      (status),
        .o_count       (count)
    );

    assign o_m_axis_tdata = {3'b000, count, popped_value};
    assign o_m_axis_tuser = status;

endmodule

`default_nettype wire

FILE: design/deq_ram.sv
// generic single-port ram with registered read
// no dependencies

`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/deq_dp.sv
// datapath: head pointer, count, entry ram and result registers
// depends on deq_pkg and deq_ram

`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire deq_pkg::t_dp_cmd                i_cmd_bus,
    output deq_pkg::t_dp_stat                    o_stat,
    input  wire deq_pkg::t_cmd                   i_cmd,
    input  wire logic [deq_pkg::VALUE_W-1:0]     i_value,
    output logic      [deq_pkg::VALUE_W-1:0]     o_popped_value,
    output deq_pkg::t_status                     o_status,
    output logic      [deq_pkg::COUNT_W-1:0]     o_count
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    t_cmd              r_cmd;
    logic [VALUE_W-1:0] r_value;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic              r_read;
    t_status           r_status;
    logic [VALUE_W-1:0] r_out_value;
    t_status           r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic              is_front;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [SW-1:0]     back_sum;
    logic [AW-1:0]     back_slot;
    logic [AW-1:0]     addr;
    logic [VALUE_W-1:0] rdata;

    assign is_front = (r_cmd inside {CMD_PUSH_FRONT, CMD_POP_FRONT});
    assign head_inc = (r_head == LAST) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? LAST : r_head - AW'(1);

    // push back writes at head+count, pop back reads at head+count-1
    always_comb begin
        back_sum = SW'(r_head) + SW'(r_count);
        if (!o_stat.is_push) begin
            back_sum = back_sum - SW'(1);
        end
        if (back_sum >= DEPTH_S) begin
            back_sum = back_sum - DEPTH_S;
        end
        back_slot = back_sum[AW-1:0];
    end

    always_comb begin
        if (is_front) begin
            addr = o_stat.is_push ? head_dec : r_head;
        end else begin
            addr = back_slot;
        end
    end

    assign o_stat.is_push = (r_cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK});
    assign o_stat.full    = (r_count == CW'(DEPTH));
    assign o_stat.empty   = (r_count == '0);

    deq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd_bus.push),
        .i_re   (i_cmd_bus.pop),
        .i_addr (addr),
        .i_wdata(r_value),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd_bus.push) begin
                r_count <= r_count + CW'(1);
                if (is_front) begin
                    r_head <= head_dec;
                end
            end else if (i_cmd_bus.pop) begin
                r_count <= r_count - CW'(1);
                if (is_front) begin
                    r_head <= head_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_in) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (i_cmd_bus.exec) begin
            r_read <= i_cmd_bus.pop;
            if (o_stat.is_push && o_stat.full) begin
                r_status <= ST_OVERFLOW;
            end else if (!o_stat.is_push && o_stat.empty) begin
                r_status <= ST_UNDERFLOW;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd_bus.load_out) begin
            r_out_value  <= r_read ? rdata : '0;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_popped_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_count        = r_out_count;

endmodule

`default_nettype wire

FILE: design/deq_ctrl.sv
// controller: sequences accept, execute and result load, owns the handshakes
// depends on deq_pkg

`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd       o_cmd_bus
);

    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd_bus.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd_bus.exec     = (r_state == S_EXEC);
        o_cmd_bus.push     = (r_state == S_EXEC) && i_stat.is_push && !i_stat.full;
        o_cmd_bus.pop      = (r_state == S_EXEC) && !i_stat.is_push && !i_stat.empty;
        o_cmd_bus.load_out = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_bus.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: design/deq_checker.sv
// port-level assertions for the double-ended queue, bound to the top level
// depends on double_ended_queue_top

`timescale 1ns / 1ps
`default_nettype none

module deq_port_checker #(
    parameter int DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    localparam logic [1:0] UNDERFLOW = 2'd1;
    localparam logic [1:0] OVERFLOW  = 2'd2;
    localparam logic [4:0] FULL_CNT  = 5'(DEPTH);

    // one command in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("item accepted while previous one still executing");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == UNDERFLOW) |->
        (o_m_axis_tdata[36:0] == 37'd0))
        else $error("underflow result with nonzero value or count");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OVERFLOW) |->
        (o_m_axis_tdata[31:0] == 32'd0 && o_m_axis_tdata[36:32] == FULL_CNT))
        else $error("overflow result without full count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue_top deq_port_checker #(
    .DEPTH(DEPTH)
) u_deq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

`default_nettype wire
